### hw/rtl/rv32s_pkg.sv
// ----------------------------------------------------------------------------
// RV32I step unit package
// Shared constants and types for the front end, queue and execution core.
// ----------------------------------------------------------------------------
package rv32s_pkg;

   localparam int MEM_WORDS = 4096;
   localparam int MEM_AW    = $clog2(MEM_WORDS);

   localparam logic [6:0]  OPC_LUI    = 7'b0110111;
   localparam logic [6:0]  OPC_AUIPC  = 7'b0010111;
   localparam logic [6:0]  OPC_OPIMM  = 7'b0010011;
   localparam logic [6:0]  OPC_OP     = 7'b0110011;
   localparam logic [6:0]  OPC_LOAD   = 7'b0000011;
   localparam logic [6:0]  OPC_STORE  = 7'b0100011;
   localparam logic [6:0]  OPC_JALR   = 7'b1100111;
   localparam logic [6:0]  OPC_JAL    = 7'b1101111;
   localparam logic [6:0]  OPC_BRANCH = 7'b1100011;
   localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
   localparam logic [6:0]  ALT_F7     = 7'b0100000;
   localparam logic [19:0] COUNT_MAX  = 20'hFFFFF;
   localparam logic [19:0] LIMIT_RESET = 20'd1000000;
   localparam logic [31:0] SYS_EXIT   = 32'd10;
   localparam logic [31:0] SYS_PRINT  = 32'd4;

   // Item as it leaves the front end
   typedef struct packed {
      logic        func;
      logic [11:0] index;
      logic [31:0] data;
   } item_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        halted;
      logic        print_valid;
      logic [31:0] print_value;
      logic        illegal_op;
      logic        mem_fault;
      logic        timed_out;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_DECODE, ST_MEM, ST_DONE
   } core_state_type;

endpackage

### hw/rtl/rv32i_integer_core_step_unit.sv
// ----------------------------------------------------------------------------
// RV32I step unit
// An item is popped in IDLE; a load item or a step stopped at fetch ends after
// FETCH, a step stopped at decode (illegal or data fault) after DECODE, and an
// executed step after MEM; DONE then sets rsp_tvalid. The core runs one item at
// a time while the queue takes new ones; it also holds while a result waits.
// Reset: synchronous; registers, pc and count cleared, running flag set, limit loaded.
// ----------------------------------------------------------------------------
module rv32i_integer_core_step_unit import rv32s_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // func, load_word_index, load_word_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // next_pc, halted, print_valid, print_value,
                                    // illegal_op, mem_fault, timed_out
   input  logic        csr_we,
   input  logic [19:0] csr_wdata
);
   logic       push, q_full, pop, not_empty;
   item_type   push_item, head;
   result_type rsp;

   rv32s_front u_front (
      .req_tvalid, .req_tready, .req_tdata,
      .push, .push_item, .q_full
   );
   rv32s_queue u_queue (
      .clock, .reset, .push, .push_item, .full(q_full),
      .pop, .not_empty, .head
   );
   rv32s_core u_core (
      .clock, .reset, .not_empty, .head, .pop, .csr_we, .csr_wdata,
      .rsp_tvalid, .rsp_tready, .rsp
   );

   // pack the result, first field lowest
   assign rsp_tdata = {3'b0, rsp.timed_out, rsp.mem_fault, rsp.illegal_op,
                       rsp.print_value, rsp.print_valid, rsp.halted, rsp.next_pc};
endmodule

### hw/rtl/rv32s_front.sv
// ----------------------------------------------------------------------------
// RV32I step unit front end
// Accepts input transfers, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module rv32s_front import rv32s_pkg::*; (
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   output logic        push,
   output item_type    push_item,
   input  logic        q_full
);
   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;
   always_comb begin
      push_item.func  = req_tdata[0];
      push_item.index = req_tdata[12:1];
      push_item.data  = req_tdata[44:13];
   end
endmodule

### hw/rtl/rv32s_queue.sv
// ----------------------------------------------------------------------------
// RV32I step unit item queue
// Four-entry queue between front end and execution core.
// ----------------------------------------------------------------------------
module rv32s_queue import rv32s_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output item_type head
);
   item_type   slot_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign full      = cnt_ff == 3'd4;
   assign not_empty = cnt_ff != 3'd0;
   assign head      = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_item;
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop)  rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'b0, push} - {2'b0, pop};
      end
   end
endmodule

### hw/rtl/rv32s_core.sv
// ----------------------------------------------------------------------------
// RV32I step unit execution core
// Runs a queued item: a word load, or a fetch, decode/execute, memory step.
// ----------------------------------------------------------------------------
module rv32s_core import rv32s_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        not_empty,
   input  item_type    head,
   output logic        pop,
   input  logic        csr_we,
   input  logic [19:0] csr_wdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output result_type  rsp
);
   logic [31:0] mem [MEM_WORDS];
   logic [31:0] rf_ff [32];
   logic [31:0] pc_ff, pc_in;
   logic        run_ff, run_in;
   logic [19:0] cnt_ff, cnt_in, lim_ff;
   core_state_type st_ff, st_in;
   logic        rv_ff;
   result_type  res_ff, res_in;
   item_type    it_ff;

   // memory port
   logic              mwe;
   logic [MEM_AW-1:0] mwa, mra;
   logic [31:0]       mwd, mrd_ff;
   logic              mrd_en;

   logic [31:0] ins_ff;
   logic [31:0] rs1, rs2, a7v, a0v;
   // decode results held for memory phase
   logic [31:0] addr_ff, addr_in, wval_ff, wval_in, npc_ff, npc_in, sdat_ff, sdat_in;
   logic [31:0] smask_ff, smask_in;
   logic        isload_ff, isload_in, isstore_ff, isstore_in, isprint_ff, isprint_in;
   logic        wr_ff, wr_in, halt_ff, halt_in, ill_in, flt_in;
   logic        rf_we;
   logic [4:0]  rf_wa;
   logic [31:0] rf_wd;

   always_ff @(posedge clock) begin
      if (mwe) mem[mwa] <= mwd;
      if (mrd_en) mrd_ff <= mem[mra];
   end

   // clear the register file on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) rf_ff[i] <= '0;
      end else if (rf_we) begin
         rf_ff[rf_wa] <= rf_wd;
      end
   end

   function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                       input logic [31:0] a, input logic [31:0] b);
      logic [4:0] sh;
      sh = b[4:0];
      unique case (f3)
         3'd0: alu = alt ? a - b : a + b;
         3'd1: alu = a << sh;
         3'd2: alu = {31'b0, $signed(a) < $signed(b)};
         3'd3: alu = {31'b0, a < b};
         3'd4: alu = a ^ b;
         3'd5: alu = alt ? 32'($signed(a) >>> sh) : a >> sh;
         3'd6: alu = a | b;
         default: alu = a & b;
      endcase
   endfunction

   logic [6:0]  op, f7;
   logic [2:0]  f3;
   logic [4:0]  rd;
   logic [31:0] immi, imms, immb, immj, eaddr;
   logic        taken, pc_bad;
   logic [4:0]  bsh;

   always_comb begin
      op = ins_ff[6:0]; rd = ins_ff[11:7]; f3 = ins_ff[14:12]; f7 = ins_ff[31:25];
      rs1 = (ins_ff[19:15] == 5'd0) ? '0 : rf_ff[ins_ff[19:15]];
      rs2 = (ins_ff[24:20] == 5'd0) ? '0 : rf_ff[ins_ff[24:20]];
      a7v = rf_ff[17];
      a0v = rf_ff[10];
      immi = {{20{ins_ff[31]}}, ins_ff[31:20]};
      imms = {{20{ins_ff[31]}}, ins_ff[31:25], ins_ff[11:7]};
      immb = {{19{ins_ff[31]}}, ins_ff[31], ins_ff[7], ins_ff[30:25], ins_ff[11:8], 1'b0};
      immj = {{11{ins_ff[31]}}, ins_ff[31], ins_ff[19:12], ins_ff[20], ins_ff[30:21], 1'b0};
      eaddr = rs1 + ((op == OPC_STORE) ? imms : immi);
      unique case (f3)
         3'd0: taken = rs1 == rs2;
         3'd1: taken = rs1 != rs2;
         3'd4: taken = $signed(rs1) < $signed(rs2);
         3'd5: taken = $signed(rs1) >= $signed(rs2);
         3'd6: taken = rs1 < rs2;
         default: taken = rs1 >= rs2;
      endcase
      pc_bad = (pc_ff[1:0] != 2'b0) || (pc_ff[31:2] >= 30'(MEM_WORDS));
      bsh = {addr_ff[1:0], 3'b0};
   end

   always_comb begin
      st_in = st_ff; pc_in = pc_ff; run_in = run_ff; cnt_in = cnt_ff;
      res_in = res_ff; pop = 1'b0;
      mwe = 1'b0; mwa = it_ff.index[MEM_AW-1:0]; mwd = it_ff.data;
      mrd_en = 1'b0; mra = pc_ff[MEM_AW+1:2];
      addr_in = addr_ff; wval_in = wval_ff; npc_in = npc_ff; sdat_in = sdat_ff;
      smask_in = smask_ff;
      isload_in = 1'b0; isstore_in = 1'b0; isprint_in = 1'b0;
      wr_in = 1'b0; halt_in = 1'b0; ill_in = 1'b0; flt_in = 1'b0;
      rf_we = 1'b0; rf_wa = rd; rf_wd = wval_ff;
      unique case (st_ff)
         ST_IDLE: begin
            // take next item once the output register is free
            if (not_empty && (!rv_ff || rsp_tready)) begin
               pop = 1'b1;
               st_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            res_in = '0;
            if (!it_ff.func) begin
               if (32'(it_ff.index) >= 32'(MEM_WORDS)) res_in.mem_fault = 1'b1;
               else mwe = 1'b1;
               st_in = ST_DONE;
            end else if (run_ff && cnt_ff >= lim_ff) begin
               run_in = 1'b0;
               st_in = ST_DONE;
            end else if (!run_ff) begin
               st_in = ST_DONE;
            end else if (pc_bad) begin
               res_in.mem_fault = 1'b1;
               st_in = ST_DONE;
            end else begin
               mrd_en = 1'b1;
               st_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            npc_in = pc_ff + 32'd4;
            addr_in = eaddr;
            unique case (op)
               OPC_LUI:   begin wr_in = 1'b1; wval_in = {ins_ff[31:12], 12'b0}; end
               OPC_AUIPC: begin wr_in = 1'b1; wval_in = pc_ff + {ins_ff[31:12], 12'b0}; end
               OPC_OPIMM: begin
                  if ((f3 == 3'd1 && f7 != 7'd0) ||
                      (f3 == 3'd5 && f7 != 7'd0 && f7 != ALT_F7)) ill_in = 1'b1;
                  else begin
                     wr_in = 1'b1;
                     wval_in = alu(f3, f3 == 3'd5 && f7 == ALT_F7, rs1, immi);
                  end
               end
               OPC_OP: begin
                  if (f7 == 7'd0 || (f7 == ALT_F7 && (f3 == 3'd0 || f3 == 3'd5))) begin
                     wr_in = 1'b1; wval_in = alu(f3, f7 == ALT_F7, rs1, rs2);
                  end else ill_in = 1'b1;
               end
               OPC_LOAD: begin
                  if (f3 == 3'd3 || f3 > 3'd5) ill_in = 1'b1;
                  else if (eaddr[31:2] >= 30'(MEM_WORDS) || (f3[1:0] == 2'd1 && eaddr[0]) ||
                           (f3[1:0] == 2'd2 && eaddr[1:0] != 2'd0)) flt_in = 1'b1;
                  else begin isload_in = 1'b1; wr_in = 1'b1; end
               end
               OPC_STORE: begin
                  if (f3 > 3'd2) ill_in = 1'b1;
                  else if (eaddr[31:2] >= 30'(MEM_WORDS) || (f3 == 3'd1 && eaddr[0]) ||
                           (f3 == 3'd2 && eaddr[1:0] != 2'd0)) flt_in = 1'b1;
                  else begin
                     isstore_in = 1'b1;
                     smask_in = (f3 == 3'd0 ? 32'hFF : (f3 == 3'd1 ? 32'hFFFF : 32'hFFFFFFFF))
                                << {eaddr[1:0], 3'b0};
                     sdat_in = rs2 << {eaddr[1:0], 3'b0};
                  end
               end
               OPC_JALR: begin
                  if (f3 != 3'd0) ill_in = 1'b1;
                  else begin
                     wr_in = 1'b1; wval_in = pc_ff + 32'd4;
                     npc_in = (rs1 + immi) & ~32'd1;
                  end
               end
               OPC_JAL: begin
                  wr_in = 1'b1; wval_in = pc_ff + 32'd4; npc_in = pc_ff + immj;
               end
               OPC_BRANCH: begin
                  if (f3 == 3'd2 || f3 == 3'd3) ill_in = 1'b1;
                  else if (taken) npc_in = pc_ff + immb;
               end
               default: begin
                  if (ins_ff != ECALL_WORD) ill_in = 1'b1;
                  else if (a7v == SYS_EXIT) halt_in = 1'b1;
                  else if (a7v == SYS_PRINT) begin
                     addr_in = a0v;
                     if (a0v[1:0] != 2'd0 || a0v[31:2] >= 30'(MEM_WORDS)) flt_in = 1'b1;
                     else isprint_in = 1'b1;
                  end
               end
            endcase
            mrd_en = 1'b1;
            mra = addr_in[MEM_AW+1:2];
            if (ill_in || flt_in) begin
               res_in.illegal_op = ill_in;
               res_in.mem_fault = flt_in;
               st_in = ST_DONE;
            end else st_in = ST_MEM;
         end
         ST_MEM: begin
            if (isload_ff) begin
               rf_wd = mrd_ff >> bsh;
               unique case (f3)
                  3'd0: rf_wd = {{24{rf_wd[7]}}, rf_wd[7:0]};
                  3'd1: rf_wd = {{16{rf_wd[15]}}, rf_wd[15:0]};
                  3'd4: rf_wd = {24'b0, rf_wd[7:0]};
                  3'd5: rf_wd = {16'b0, rf_wd[15:0]};
                  default: ;
               endcase
            end
            rf_we = wr_ff && rd != 5'd0;
            if (isstore_ff) begin
               mwe = 1'b1;
               mwa = addr_ff[MEM_AW+1:2];
               mwd = (mrd_ff & ~smask_ff) | (sdat_ff & smask_ff);
            end
            if (isprint_ff) begin
               res_in.print_valid = 1'b1;
               res_in.print_value = mrd_ff;
            end
            pc_in = npc_ff;
            if (cnt_ff != COUNT_MAX) cnt_in = cnt_ff + 20'd1;
            if (halt_ff || cnt_in >= lim_ff) run_in = 1'b0;
            st_in = ST_DONE;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
      res_in.next_pc = pc_in;
      res_in.halted = !run_in;
      res_in.timed_out = cnt_in >= lim_ff;
   end

   always_ff @(posedge clock) begin
      if (pop) it_ff <= head;
      if (st_ff == ST_FETCH) ins_ff <= mem[pc_ff[MEM_AW+1:2]];
      addr_ff <= addr_in; wval_ff <= wval_in; npc_ff <= npc_in; sdat_ff <= sdat_in;
      smask_ff <= smask_in;
      if (st_ff == ST_DECODE) begin
         isload_ff <= isload_in; isstore_ff <= isstore_in; isprint_ff <= isprint_in;
         wr_ff <= wr_in; halt_ff <= halt_in;
      end
      if (st_ff != ST_IDLE) res_ff <= res_in;
      if (reset) begin
         st_ff <= ST_IDLE; pc_ff <= '0; run_ff <= 1'b1; cnt_ff <= '0;
         lim_ff <= LIMIT_RESET; rv_ff <= 1'b0;
      end else begin
         st_ff <= (st_ff == ST_DONE) ? ST_IDLE : st_in;
         pc_ff <= pc_in; run_ff <= run_in; cnt_ff <= cnt_in;
         if (csr_we) lim_ff <= csr_wdata;
         if (st_ff == ST_DONE) rv_ff <= 1'b1;
         else if (rsp_tready) rv_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp = res_ff;
endmodule
